// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OCTA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("octa assertion failed");

// next-cycle implication
`define OCTA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("octa assertion failed");

`endif

// ===== rtl/core/octa_pkg.sv =====
// ----------------------------------------------------------------------------
// Octant atan2 package
// Widths, direction codes, pipeline stage types and the arctangent ROM.
// ----------------------------------------------------------------------------
package octa_pkg;

    localparam int COORD_W = 15;
    localparam int DIFF_W  = 16;
    localparam int MAG_W   = 15;
    localparam int QUO_W   = 7;
    localparam int ANG_W   = 7;
    localparam int ROM_W   = 5;
    localparam int ROM_N   = 128;

    localparam logic [ANG_W-1:0] ANG_E  = 7'd0;
    localparam logic [ANG_W-1:0] ANG_NE = 7'd16;
    localparam logic [ANG_W-1:0] ANG_N  = 7'd32;
    localparam logic [ANG_W-1:0] ANG_NW = 7'd48;
    localparam logic [ANG_W-1:0] ANG_W_ = 7'd64;
    localparam logic [ANG_W-1:0] ANG_SW = 7'd80;
    localparam logic [ANG_W-1:0] ANG_S  = 7'd96;
    localparam logic [ANG_W-1:0] ANG_SE = 7'd112;

    localparam logic [ROM_W-1:0] ATAN_ROM [ROM_N] = '{
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,
        5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,
        5'd2,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd4,
        5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd5,  5'd5,
        5'd5,  5'd5,  5'd5,  5'd5,  5'd5,  5'd6,  5'd6,  5'd6,
        5'd6,  5'd6,  5'd6,  5'd6,  5'd7,  5'd7,  5'd7,  5'd7,
        5'd7,  5'd7,  5'd7,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
        5'd8,  5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,
        5'd9,  5'd9,  5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
        5'd10, 5'd10, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
        5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12,
        5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13,
        5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd14, 5'd14,
        5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14,
        5'd14, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16
    };

    typedef struct packed {
        logic             valid;
        logic [MAG_W-1:0] dx;
        logic [MAG_W-1:0] dy;
        logic             right;
        logic             up;
    } t_delta;

    typedef struct packed {
        logic             valid;
        logic             special;
        logic [ANG_W-1:0] spec_angle;
        logic             shallow;
        logic             right;
        logic             up;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div;

endpackage

// ===== rtl/core/octa_ifs.sv =====
// ----------------------------------------------------------------------------
// Octant atan2 stream interfaces
// Point-pair input channel and angle output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface octa_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [octa_pkg::COORD_W-1:0] from_x;
    logic signed [octa_pkg::COORD_W-1:0] from_y;
    logic signed [octa_pkg::COORD_W-1:0] to_x;
    logic signed [octa_pkg::COORD_W-1:0] to_y;

    modport source (output valid, from_x, from_y, to_x, to_y, input ready);
    modport sink   (input valid, from_x, from_y, to_x, to_y, output ready);
endinterface

interface octa_ang_if;
    logic                          valid;
    logic                          ready;
    logic [octa_pkg::ANG_W-1:0]    angle;

    modport source (output valid, angle, input ready);
    modport sink   (input valid, angle, output ready);
endinterface

// ===== rtl/core/octa_prep.sv =====
// ----------------------------------------------------------------------------
// Octant atan2 front end
// Two stages: signed differences and magnitudes, then special-case
// classification and min/max selection for the divider.
// ----------------------------------------------------------------------------
module octa_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  logic signed [octa_pkg::COORD_W-1:0] i_from_x,
    input  logic signed [octa_pkg::COORD_W-1:0] i_from_y,
    input  logic signed [octa_pkg::COORD_W-1:0] i_to_x,
    input  logic signed [octa_pkg::COORD_W-1:0] i_to_y,
    output octa_pkg::t_div                      o_div
);

    logic signed [octa_pkg::DIFF_W-1:0] n_sdx;
    logic signed [octa_pkg::DIFF_W-1:0] n_sdy;
    logic        [octa_pkg::DIFF_W-1:0] n_adx;
    logic        [octa_pkg::DIFF_W-1:0] n_ady;
    octa_pkg::t_delta                   n_delta;
    octa_pkg::t_delta                   r_delta;
    octa_pkg::t_div                     n_div;
    octa_pkg::t_div                     r_div;

    always_comb begin
        n_sdx = octa_pkg::DIFF_W'(i_to_x) - octa_pkg::DIFF_W'(i_from_x);
        n_sdy = octa_pkg::DIFF_W'(i_to_y) - octa_pkg::DIFF_W'(i_from_y);
        n_adx = n_sdx[octa_pkg::DIFF_W-1] ? -n_sdx : n_sdx;
        n_ady = n_sdy[octa_pkg::DIFF_W-1] ? -n_sdy : n_sdy;
        n_delta.valid = i_valid;
        n_delta.dx    = n_adx[octa_pkg::MAG_W-1:0];
        n_delta.dy    = n_ady[octa_pkg::MAG_W-1:0];
        n_delta.right = !n_sdx[octa_pkg::DIFF_W-1];
        n_delta.up    = n_sdy[octa_pkg::DIFF_W-1] || (n_sdy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta.valid <= 1'b0;
        end else if (i_adv) begin
            r_delta <= n_delta;
        end
    end

    always_comb begin
        n_div.valid   = r_delta.valid;
        n_div.right   = r_delta.right;
        n_div.up      = r_delta.up;
        n_div.shallow = r_delta.dy < r_delta.dx;
        n_div.mx      = n_div.shallow ? r_delta.dx : r_delta.dy;
        n_div.rem     = n_div.shallow ? r_delta.dy : r_delta.dx;
        n_div.quo     = '0;
        n_div.special = 1'b1;
        priority if (r_delta.dx == r_delta.dy) begin
            if (r_delta.right) begin
                n_div.spec_angle = r_delta.up ? octa_pkg::ANG_NE : octa_pkg::ANG_SE;
            end else begin
                n_div.spec_angle = r_delta.up ? octa_pkg::ANG_NW : octa_pkg::ANG_SW;
            end
        end else if (r_delta.dx == '0) begin
            n_div.spec_angle = r_delta.up ? octa_pkg::ANG_N : octa_pkg::ANG_S;
        end else if (r_delta.dy == '0) begin
            n_div.spec_angle = r_delta.right ? octa_pkg::ANG_E : octa_pkg::ANG_W_;
        end else begin
            n_div.special    = 1'b0;
            n_div.spec_angle = octa_pkg::ANG_E;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_adv) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== rtl/core/octa_div_step.sv =====
// ----------------------------------------------------------------------------
// Octant atan2 divider step
// One restoring division stage: yields one quotient bit of min/max.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module octa_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  octa_pkg::t_div i_div,
    output octa_pkg::t_div o_div
);

    logic [octa_pkg::MAG_W:0] n_rem2;
    logic [octa_pkg::MAG_W:0] n_diff;
    logic                     n_bit;
    octa_pkg::t_div           n_div;
    octa_pkg::t_div           r_div;

    always_comb begin
        n_rem2 = {i_div.rem, 1'b0};
        n_diff = n_rem2 - {1'b0, i_div.mx};
        n_bit  = n_rem2 >= {1'b0, i_div.mx};
        n_div      = i_div;
        n_div.rem  = n_bit ? n_diff[octa_pkg::MAG_W-1:0] : n_rem2[octa_pkg::MAG_W-1:0];
        n_div.quo  = {i_div.quo[octa_pkg::QUO_W-2:0], n_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_adv) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

    `OCTA_ASSERT_IMP(a_rem_below_max, r_div.valid && !r_div.special, r_div.rem < r_div.mx)
    `OCTA_ASSERT_IMP(a_max_nonzero, r_div.valid && !r_div.special, r_div.mx != '0)

endmodule

// ===== rtl/core/octa_fold.sv =====
// ----------------------------------------------------------------------------
// Octant atan2 fold stage
// Arctangent ROM lookup, octant folding and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module octa_fold (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  octa_pkg::t_div              i_div,
    output logic                        o_valid,
    output logic [octa_pkg::ANG_W-1:0]  o_angle
);

    logic [octa_pkg::ANG_W-1:0] n_a;
    logic [octa_pkg::ANG_W-1:0] n_angle;
    logic                       r_valid;
    logic [octa_pkg::ANG_W-1:0] r_angle;

    always_comb begin
        n_a = octa_pkg::ANG_W'(octa_pkg::ATAN_ROM[i_div.quo]);
        unique case ({i_div.shallow, i_div.right, i_div.up})
            3'b111:  n_angle = n_a;
            3'b110:  n_angle = octa_pkg::ANG_E - n_a;
            3'b101:  n_angle = octa_pkg::ANG_W_ - n_a;
            3'b100:  n_angle = octa_pkg::ANG_W_ + n_a;
            3'b011:  n_angle = octa_pkg::ANG_N - n_a;
            3'b010:  n_angle = octa_pkg::ANG_S + n_a;
            3'b001:  n_angle = octa_pkg::ANG_N + n_a;
            3'b000:  n_angle = octa_pkg::ANG_S - n_a;
            default: n_angle = octa_pkg::ANG_E;
        endcase
        if (i_div.special) begin
            n_angle = i_div.spec_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_div.valid;
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

    `OCTA_ASSERT_NXT(a_valid_lands, i_adv && i_div.valid, r_valid)
    `OCTA_ASSERT_IMP(a_special_on_octant, i_div.valid && i_div.special, i_div.spec_angle[3:0] == 4'd0)

endmodule

// ===== rtl/core/octant_atan2_angle.sv =====
// ----------------------------------------------------------------------------
// Octant atan2 angle unit
// Direction code (128 steps per turn, y down) from one point to another.
//
// i_pt carries one point pair per transaction (from_x, from_y, to_x, to_y,
// 15-bit signed, 7 fraction bits). o_ang returns one 7-bit angle per pair:
// 0 right, 32 up, 64 left, 96 down; equal points give 16.
// Stages: magnitudes, classification, seven restoring divide stages (one
// quotient bit each), then ROM lookup and fold into the output register.
// One transaction is taken per cycle when not stalled; the divide chain
// sets the depth. Reset clears all stage valid bits; no transaction is in
// flight afterward. When the receiver stalls with a result held, the whole
// pipeline freezes and i_pt.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module octant_atan2_angle (
    input  logic       i_clk,
    input  logic       i_rst_n,
    octa_pt_if.sink    i_pt,
    octa_ang_if.source o_ang
);

    logic                       w_adv;
    logic                       w_valid;
    logic [octa_pkg::ANG_W-1:0] w_angle;
    octa_pkg::t_div             w_div [octa_pkg::QUO_W+1];

    assign w_adv      = !w_valid || o_ang.ready;
    assign i_pt.ready = w_adv;

    octa_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_pt.valid),
        .i_from_x (i_pt.from_x),
        .i_from_y (i_pt.from_y),
        .i_to_x   (i_pt.to_x),
        .i_to_y   (i_pt.to_y),
        .o_div    (w_div[0])
    );

    for (genvar g = 0; g < octa_pkg::QUO_W; g++) begin : g_div
        octa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_div   (w_div[g]),
            .o_div   (w_div[g+1])
        );
    end

    octa_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_div   (w_div[octa_pkg::QUO_W]),
        .o_valid (w_valid),
        .o_angle (w_angle)
    );

    assign o_ang.valid = w_valid;
    assign o_ang.angle = w_angle;

endmodule
